### rtl/core/mhr_pkg.sv
// shared types and constants for the mesh hop latency router
// used by every module under rtl/core; depends on nothing
package mhr_pkg;

	localparam int CORE_W    = 6;
	localparam int TIME_W    = 48;
	localparam int PAY_W     = 16;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_CORES = 64;

	// config register widths
	localparam int MW_W  = 7;
	localparam int CC_W  = 7;
	localparam int BW_W  = 11;
	localparam int HOP_W = 8;
	localparam int HDR_W = 8;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MESH_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_BANDWIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_LATENCY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES   = 3'd4;

	// config reset values
	localparam logic [MW_W-1:0]  RST_MESH_WIDTH     = 7'd8;
	localparam logic [CC_W-1:0]  RST_CORE_COUNT     = 7'd64;
	localparam logic [BW_W-1:0]  RST_LINK_BANDWIDTH = 11'd64;
	localparam logic [HOP_W-1:0] RST_HOP_LATENCY    = 8'd1;
	localparam logic [HDR_W-1:0] RST_HEADER_BYTES   = 8'd32;

	// byte count to bit count
	localparam int BYTE_SHIFT = 3;

	// shared restoring divider
	localparam int DIV_W     = 20;
	localparam int DIV_CNT_W = 5;
	localparam int REM_W     = BW_W;
	localparam logic [DIV_CNT_W-1:0] SER_STEPS   = DIV_CNT_W'(DIV_W);
	localparam logic [DIV_CNT_W-1:0] COORD_STEPS = DIV_CNT_W'(CORE_W);

	// mesh coordinates and hop product
	localparam int XY_W   = MW_W;
	localparam int DIST_W = XY_W + 1;
	localparam int PROD_W = DIST_W + HOP_W;

	typedef enum logic [1:0] {
		DIV_OP_SER,
		DIV_OP_SRC,
		DIV_OP_DST
	} div_op_t;

	typedef struct packed {
		logic    load_item;
		logic    div_start;
		div_op_t start_op;
		logic    div_cap;
		div_op_t cap_op;
		logic    bc_init;
		logic    calc;
		logic    emit;
		logic    advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
		logic bcast;
		logic last;
	} ctrl_sts_t;

endpackage

### rtl/core/mhr_div.sv
// restoring divider, one quotient bit per cycle, run for a given step count
// the dividend comes in left aligned; depends on mhr_pkg
module mhr_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mhr_pkg::DIV_W-1:0]      dividend,
	input  logic [mhr_pkg::REM_W-1:0]      divisor,
	input  logic [mhr_pkg::DIV_CNT_W-1:0]  steps,
	output logic                           done,
	output logic [mhr_pkg::DIV_W-1:0]      quotient,
	output logic [mhr_pkg::REM_W-1:0]      remainder
);

	localparam logic [mhr_pkg::DIV_CNT_W-1:0] DIV_CNT_ONE = 1;

	logic                          busy_q;
	logic                          done_q;
	logic [mhr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [mhr_pkg::DIV_W-1:0]     quo_q;
	logic [mhr_pkg::REM_W-1:0]     rem_q;
	logic [mhr_pkg::REM_W-1:0]     div_q;

	logic [mhr_pkg::REM_W:0] rem_shift;
	logic                    ge;
	logic [mhr_pkg::REM_W:0] rem_sub;

	assign rem_shift = {rem_q, quo_q[mhr_pkg::DIV_W-1]};
	assign ge        = rem_shift >= {1'b0, div_q};
	assign rem_sub   = rem_shift - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_ONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mhr_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[mhr_pkg::REM_W-1:0] : rem_shift[mhr_pkg::REM_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/core/mhr_ctrl.sv
// controller state machine: sequences divisions, latency and result issue
// drives commands into mhr_dp and reads its status; depends on mhr_pkg
module mhr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mhr_pkg::ctrl_sts_t sts,
	output mhr_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_DIV_SER = 6'b000010,
		ST_DIV_SRC = 6'b000100,
		ST_DIV_DST = 6'b001000,
		ST_LAT     = 6'b010000,
		ST_EMIT    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.start_op = mhr_pkg::DIV_OP_SER;
		cmd.cap_op   = mhr_pkg::DIV_OP_SER;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.div_start = 1'b1;
					cmd.start_op  = mhr_pkg::DIV_OP_SER;
					state_d       = ST_DIV_SER;
				end
			end
			ST_DIV_SER: begin
				if (sts.div_done) begin
					cmd.div_cap   = 1'b1;
					cmd.cap_op    = mhr_pkg::DIV_OP_SER;
					cmd.div_start = 1'b1;
					cmd.start_op  = mhr_pkg::DIV_OP_SRC;
					state_d       = ST_DIV_SRC;
				end
			end
			ST_DIV_SRC: begin
				if (sts.div_done) begin
					cmd.div_cap = 1'b1;
					cmd.cap_op  = mhr_pkg::DIV_OP_SRC;
					if (sts.bcast) begin
						cmd.bc_init = 1'b1;
						state_d     = ST_LAT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.start_op  = mhr_pkg::DIV_OP_DST;
						state_d       = ST_DIV_DST;
					end
				end
			end
			ST_DIV_DST: begin
				if (sts.div_done) begin
					cmd.div_cap = 1'b1;
					cmd.cap_op  = mhr_pkg::DIV_OP_DST;
					state_d     = ST_LAT;
				end
			end
			ST_LAT: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_LAT;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/mhr_dp.sv
// datapath: config registers, item registers, shared divider, hop latency
// and the output register; depends on mhr_pkg and mhr_div
module mhr_dp #(
	parameter int MAX_CORES = mhr_pkg::MAX_CORES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mhr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mhr_pkg::CFG_W-1:0]       cfg_data,
	input  logic [mhr_pkg::CORE_W-1:0]      sender_core,
	input  logic [mhr_pkg::CORE_W-1:0]      receiver_core,
	input  logic                            is_broadcast,
	input  logic [mhr_pkg::PAY_W-1:0]       payload_bytes,
	input  logic [mhr_pkg::TIME_W-1:0]      send_time,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [mhr_pkg::CORE_W-1:0]      dest_core,
	output logic [mhr_pkg::TIME_W-1:0]      arrival_time,
	output logic                            last,
	input  mhr_pkg::ctrl_cmd_t              cmd,
	output mhr_pkg::ctrl_sts_t              sts
);

	localparam logic [mhr_pkg::CC_W-1:0] MAX_N = mhr_pkg::CC_W'(MAX_CORES);
	localparam int ALIGN = mhr_pkg::DIV_W - mhr_pkg::CORE_W;
	localparam int SUM_W = mhr_pkg::PAY_W + 1;

	logic [mhr_pkg::MW_W-1:0]  mesh_width_q;
	logic [mhr_pkg::CC_W-1:0]  core_count_q;
	logic [mhr_pkg::BW_W-1:0]  link_bw_q;
	logic [mhr_pkg::HOP_W-1:0] hop_lat_q;
	logic [mhr_pkg::HDR_W-1:0] header_q;

	logic [mhr_pkg::CORE_W-1:0] sender_q;
	logic [mhr_pkg::CORE_W-1:0] receiver_q;
	logic                       bcast_q;
	logic [mhr_pkg::TIME_W-1:0] cur_q;
	logic [mhr_pkg::DIV_W-1:0]  ser_q;
	logic [mhr_pkg::XY_W-1:0]   sx_q;
	logic [mhr_pkg::XY_W-1:0]   sy_q;
	logic [mhr_pkg::XY_W-1:0]   x_q;
	logic [mhr_pkg::XY_W-1:0]   y_q;
	logic [mhr_pkg::CORE_W-1:0] idx_q;
	logic [mhr_pkg::PROD_W-1:0] prod_q;

	logic                       out_valid_q;
	logic [mhr_pkg::CORE_W-1:0] dest_q;
	logic [mhr_pkg::TIME_W-1:0] arr_q;
	logic                       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_width_q <= mhr_pkg::RST_MESH_WIDTH;
			core_count_q <= mhr_pkg::RST_CORE_COUNT;
			link_bw_q    <= mhr_pkg::RST_LINK_BANDWIDTH;
			hop_lat_q    <= mhr_pkg::RST_HOP_LATENCY;
			header_q     <= mhr_pkg::RST_HEADER_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				mhr_pkg::REG_MESH_WIDTH:     mesh_width_q <= cfg_data[mhr_pkg::MW_W-1:0];
				mhr_pkg::REG_CORE_COUNT:     core_count_q <= cfg_data[mhr_pkg::CC_W-1:0];
				mhr_pkg::REG_LINK_BANDWIDTH: link_bw_q    <= cfg_data[mhr_pkg::BW_W-1:0];
				mhr_pkg::REG_HOP_LATENCY:    hop_lat_q    <= cfg_data[mhr_pkg::HOP_W-1:0];
				mhr_pkg::REG_HEADER_BYTES:   header_q     <= cfg_data[mhr_pkg::HDR_W-1:0];
				default: ;
			endcase
		end
	end

	// zero width, bandwidth and core count behave as one; core count caps at MAX_CORES
	logic [mhr_pkg::MW_W-1:0] eff_w;
	logic [mhr_pkg::BW_W-1:0] eff_bw;
	logic [mhr_pkg::CC_W-1:0] eff_n;

	assign eff_w  = (mesh_width_q == '0) ? mhr_pkg::MW_W'(1) : mesh_width_q;
	assign eff_bw = (link_bw_q == '0) ? mhr_pkg::BW_W'(1) : link_bw_q;
	always_comb begin
		if (core_count_q == '0) begin
			eff_n = mhr_pkg::CC_W'(1);
		end else if (core_count_q > MAX_N) begin
			eff_n = MAX_N;
		end else begin
			eff_n = core_count_q;
		end
	end

	// divider operand select
	logic [SUM_W-1:0]                 byte_sum;
	logic [mhr_pkg::DIV_W-1:0]        ser_num;
	logic [mhr_pkg::DIV_W-1:0]        div_dividend;
	logic [mhr_pkg::REM_W-1:0]        div_divisor;
	logic [mhr_pkg::DIV_CNT_W-1:0]    div_steps;
	logic                             div_done;
	logic [mhr_pkg::DIV_W-1:0]        div_quo;
	logic [mhr_pkg::REM_W-1:0]        div_rem;

	assign byte_sum = SUM_W'(payload_bytes) + SUM_W'(header_q);
	// ceiling division: add divisor minus one before dividing
	assign ser_num  = mhr_pkg::DIV_W'({byte_sum, {mhr_pkg::BYTE_SHIFT{1'b0}}})
		+ mhr_pkg::DIV_W'(eff_bw - 1'b1);

	always_comb begin
		case (cmd.start_op)
			mhr_pkg::DIV_OP_SER: begin
				div_dividend = ser_num;
				div_divisor  = eff_bw;
				div_steps    = mhr_pkg::SER_STEPS;
			end
			mhr_pkg::DIV_OP_SRC: begin
				div_dividend = {sender_q, {ALIGN{1'b0}}};
				div_divisor  = mhr_pkg::REM_W'(eff_w);
				div_steps    = mhr_pkg::COORD_STEPS;
			end
			mhr_pkg::DIV_OP_DST: begin
				div_dividend = {receiver_q, {ALIGN{1'b0}}};
				div_divisor  = mhr_pkg::REM_W'(eff_w);
				div_steps    = mhr_pkg::COORD_STEPS;
			end
			default: begin
				div_dividend = ser_num;
				div_divisor  = eff_bw;
				div_steps    = mhr_pkg::SER_STEPS;
			end
		endcase
	end

	mhr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.steps     (div_steps),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// hop distance
	logic [mhr_pkg::XY_W-1:0]   dx;
	logic [mhr_pkg::XY_W-1:0]   dy;
	logic [mhr_pkg::DIST_W-1:0] hop_dist;

	assign dx       = (x_q >= sx_q) ? (x_q - sx_q) : (sx_q - x_q);
	assign dy       = (y_q >= sy_q) ? (y_q - sy_q) : (sy_q - y_q);
	assign hop_dist = mhr_pkg::DIST_W'(dx) + mhr_pkg::DIST_W'(dy);

	logic [mhr_pkg::TIME_W-1:0] ser_add;
	logic [mhr_pkg::TIME_W-1:0] arrival_d;
	logic                       is_last;
	logic [mhr_pkg::XY_W-1:0]   x_inc;

	// a packet to itself carries no serialization delay
	assign ser_add   = (idx_q != sender_q) ? mhr_pkg::TIME_W'(ser_q) : '0;
	assign arrival_d = cur_q + mhr_pkg::TIME_W'(prod_q) + ser_add;
	assign is_last   = !bcast_q || ({1'b0, idx_q} == (eff_n - 1'b1));
	assign x_inc     = x_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sender_q   <= sender_core;
			receiver_q <= receiver_core;
			bcast_q    <= is_broadcast;
			cur_q      <= send_time;
		end else if (cmd.advance) begin
			cur_q <= cur_q + mhr_pkg::TIME_W'(ser_q);
		end

		if (cmd.div_cap) begin
			case (cmd.cap_op)
				mhr_pkg::DIV_OP_SER: begin
					ser_q <= div_quo;
				end
				mhr_pkg::DIV_OP_SRC: begin
					sx_q <= mhr_pkg::XY_W'(div_rem[mhr_pkg::CORE_W-1:0]);
					sy_q <= mhr_pkg::XY_W'(div_quo[mhr_pkg::CORE_W-1:0]);
				end
				mhr_pkg::DIV_OP_DST: begin
					x_q   <= mhr_pkg::XY_W'(div_rem[mhr_pkg::CORE_W-1:0]);
					y_q   <= mhr_pkg::XY_W'(div_quo[mhr_pkg::CORE_W-1:0]);
					idx_q <= receiver_q;
				end
				default: ;
			endcase
		end

		if (cmd.bc_init) begin
			x_q   <= '0;
			y_q   <= '0;
			idx_q <= '0;
		end else if (cmd.advance) begin
			idx_q <= idx_q + 1'b1;
			// walk the row, wrapping to the next one at the mesh width
			if (x_inc == eff_w) begin
				x_q <= '0;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_inc;
			end
		end

		if (cmd.calc) begin
			prod_q <= hop_dist * hop_lat_q;
		end

		if (cmd.emit) begin
			dest_q <= idx_q;
			arr_q  <= arrival_d;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.bcast    = bcast_q;
	assign sts.last     = is_last;

	assign out_valid    = out_valid_q;
	assign dest_core    = dest_q;
	assign arrival_time = arr_q;
	assign last         = last_q;

endmodule

### rtl/core/mesh_hop_latency_router.sv
// top level of the mesh hop latency router: controller plus datapath
// depends on mhr_pkg, mhr_ctrl, mhr_dp
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   sender_core receiver_core is_broadcast
//                                         payload_bytes send_time
// out      output     out_valid/out_stall dest_core arrival_time last
// cfg      input      cfg_we              cfg_index cfg_data
//
// one packet at a time; all divides run one bit a cycle on one shared divider
// unicast: serialization, source and destination divides, distance multiply,
// then the result issue; the input opens as the result appears at the output
// broadcast: no destination divide; each core reached then takes the
// distance multiply, then the time add
// a stalled output holds the sequencer in its issue state; a result that
// waits to be taken does not block the next packet from entering
// reset restores the config registers to their defaults and empties the output
module mesh_hop_latency_router #(
	parameter int MAX_CORES = mhr_pkg::MAX_CORES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mhr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mhr_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mhr_pkg::CORE_W-1:0]      sender_core,
	input  logic [mhr_pkg::CORE_W-1:0]      receiver_core,
	input  logic                            is_broadcast,
	input  logic [mhr_pkg::PAY_W-1:0]       payload_bytes,
	input  logic [mhr_pkg::TIME_W-1:0]      send_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mhr_pkg::CORE_W-1:0]      dest_core,
	output logic [mhr_pkg::TIME_W-1:0]      arrival_time,
	output logic                            last
);

	mhr_pkg::ctrl_cmd_t cmd;
	mhr_pkg::ctrl_sts_t sts;

	mhr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhr_dp #(
		.MAX_CORES (MAX_CORES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sender_core   (sender_core),
		.receiver_core (receiver_core),
		.is_broadcast  (is_broadcast),
		.payload_bytes (payload_bytes),
		.send_time     (send_time),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.dest_core     (dest_core),
		.arrival_time  (arrival_time),
		.last          (last),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

### rtl/core/mhr_chk.sv
// port level checks for mesh_hop_latency_router, bound to the top level
// depends on mhr_pkg and mesh_hop_latency_router
module mhr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [mhr_pkg::CORE_W-1:0]      dest_core,
	input logic [mhr_pkg::TIME_W-1:0]      arrival_time,
	input logic                            last
);

	// an accepted item keeps the input closed at least through the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accepted item");

	// a broadcast still in progress keeps the input closed
	a_busy_mid_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> in_stall)
		else $error("input open while a packet has results left");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dest_core)
			&& $stable(arrival_time) && $stable(last))
		else $error("stalled result changed");

	// a taken broadcast result that is not the last is followed by no result or by one for a core other than zero
	a_core_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid || (dest_core != '0))
		else $error("broadcast result order broken");

endmodule

bind mesh_hop_latency_router mhr_chk u_mhr_chk (.*);
